// File: sv/rlen_pkg.sv
// Shared types and constants for the run-length encoder with null rows.
package rlen_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int PORT_VALUE_WIDTH = 64;
   localparam int COUNT_WIDTH = 16;

   localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = '1;
   localparam logic [COUNT_WIDTH-1:0] LIMIT_MIN = COUNT_WIDTH'(2);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   // Largest number of runs one row can produce.
   localparam int MAX_RUNS = 2;
   localparam int RUN_CNT_WIDTH = $clog2(MAX_RUNS + 1);

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   is_valid;
      logic                   end_of_stream;
   } item_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] run_value;
      logic [COUNT_WIDTH-1:0] run_len;
      logic                   no_valid_seen;
      logic                   last_result;
   } run_type;

endpackage

// File: sv/rlen_step.sv
// Run state and the per-row encoding step.
module rlen_step
   import rlen_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  item_type                 item,
   input  logic [COUNT_WIDTH-1:0]   limit,
   output logic [RUN_CNT_WIDTH-1:0] emit_count,
   output run_type                  run0,
   output run_type                  run1
);

   logic [VALUE_WIDTH-1:0] held_value_ff, held_value_in;
   logic [COUNT_WIDTH-1:0] held_count_ff, held_count_in;
   logic                   none_valid_ff, none_valid_in;

   logic [VALUE_WIDTH-1:0] upd_value;
   logic [COUNT_WIDTH-1:0] upd_count;
   logic [COUNT_WIDTH-1:0] post_count;
   logic                   upd_none;
   logic                   differ_emit;
   logic                   limit_emit;
   logic [COUNT_WIDTH-1:0] eff_limit;
   run_type                differ_run;
   run_type                limit_run;
   run_type                flush_run;

   always_comb begin
      eff_limit = (limit < LIMIT_MIN) ? LIMIT_MIN : limit;
      upd_value = held_value_ff;
      upd_count = held_count_ff + COUNT_WIDTH'(1);
      upd_none = none_valid_ff;
      differ_emit = 1'b0;
      if (item.is_valid) begin
         if (none_valid_ff) begin
            upd_value = item.value;
            upd_none = 1'b0;
         end else if (held_value_ff != item.value) begin
            differ_emit = (held_count_ff != '0);
            upd_value = item.value;
            upd_count = COUNT_WIDTH'(1);
         end
      end
      limit_emit = (upd_count >= eff_limit);
      post_count = limit_emit ? '0 : upd_count;

      differ_run = '{run_value: held_value_ff, run_len: held_count_ff,
                     no_valid_seen: none_valid_ff, last_result: 1'b0};
      limit_run = '{run_value: upd_value, run_len: upd_count,
                    no_valid_seen: upd_none, last_result: 1'b0};
      flush_run = '{run_value: upd_value, run_len: post_count,
                    no_valid_seen: upd_none, last_result: 1'b1};

      // A differing value restarts the count at one, so it never meets the limit too.
      emit_count = RUN_CNT_WIDTH'(differ_emit) + RUN_CNT_WIDTH'(limit_emit)
                 + RUN_CNT_WIDTH'(item.end_of_stream);
      if (differ_emit) begin
         run0 = differ_run;
      end else if (limit_emit) begin
         run0 = limit_run;
      end else begin
         run0 = flush_run;
      end
      run0.last_result = (emit_count == RUN_CNT_WIDTH'(1));
      run1 = flush_run;

      if (item.end_of_stream) begin
         held_value_in = '0;
         held_count_in = '0;
         none_valid_in = 1'b1;
      end else begin
         held_value_in = upd_value;
         held_count_in = post_count;
         none_valid_in = upd_none;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_value_ff <= '0;
         held_count_ff <= '0;
         none_valid_ff <= 1'b1;
      end else if (fire) begin
         held_value_ff <= held_value_in;
         held_count_ff <= held_count_in;
         none_valid_ff <= none_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fire && item.end_of_stream |=> held_count_ff == '0 && none_valid_ff)
      else $error("Stream state not cleared after end of stream.");

   assert property (@(posedge clock) disable iff (reset)
      none_valid_ff |-> held_value_ff == '0)
      else $error("Held value set before any valid value.");

   assert property (@(posedge clock) disable iff (reset)
      fire && !item.end_of_stream |-> emit_count <= RUN_CNT_WIDTH'(1))
      else $error("Two runs from a row without end of stream.");

endmodule

// File: sv/rlen_run_fifo.sv
// Small result queue that takes up to two runs a cycle and gives one.
module rlen_run_fifo
   import rlen_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [RUN_CNT_WIDTH-1:0] push_count,
   input  run_type                  push_run0,
   input  run_type                  push_run1,
   input  logic                     pop,
   output run_type                  head,
   output logic                     not_empty,
   output logic                     has_room
);

   run_type                     run_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_WIDTH-1:0]   count_ff, count_in;
   logic                        do_pop;

   always_comb begin
      do_pop = pop && not_empty;
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_WIDTH'(push_count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_WIDTH'(do_pop);
      count_in = count_ff + FIFO_CNT_WIDTH'(push_count) - FIFO_CNT_WIDTH'(do_pop);
   end

   assign not_empty = (count_ff != '0);
   assign has_room = (count_ff <= FIFO_CNT_WIDTH'(FIFO_DEPTH - MAX_RUNS));
   assign head = run_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != '0) begin
         run_mem_ff[wr_ptr_ff] <= push_run0;
      end
      if (push_count == RUN_CNT_WIDTH'(MAX_RUNS)) begin
         run_mem_ff[wr_ptr_ff + FIFO_PTR_WIDTH'(1)] <= push_run1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_WIDTH'(FIFO_DEPTH))
      else $error("Result queue holds more words than its depth.");

   assert property (@(posedge clock) disable iff (reset)
      push_count != '0 |-> has_room)
      else $error("Runs pushed into a result queue without room.");

   assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 && push_count == '0 |=> count_ff == '0)
      else $error("Result queue count moved without a push.");

endmodule

// File: sv/rle_encoder_with_nulls_core.sv
// Top level of the run-length encoder for one column stream with null rows.
//
// Rows arrive on the req_ channel (value, valid bit, end-of-stream mark) under a
// valid/ready handshake; encoded runs leave on the rsp_ channel in the same way.
// Each row yields zero, one or two runs, and the last run of a row carries
// rsp_last_result. The csr_ port writes the forced-emission limit.
// A row is taken into an input register, goes through the encoding step into the
// result queue once the queue has room, and its runs are offered on rsp_ from there.
// One row is accepted per cycle while the four-word result queue has room for
// two more words; the output gives one word per cycle while rsp_ready is high,
// so rows that produce two runs limit the rate at which rows are taken.
// Reset clears the run state and the queue and sets the limit to 65535.
// When the receiver stalls, words collect in the queue; once fewer than two free
// places remain, the row in the input register waits and req_ready falls.
// No word is lost or repeated.
module rle_encoder_with_nulls_core
   import rlen_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [PORT_VALUE_WIDTH-1:0] req_value,
   input  logic                        req_is_valid,
   input  logic                        req_end_of_stream,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [PORT_VALUE_WIDTH-1:0] rsp_run_value,
   output logic [COUNT_WIDTH-1:0]      rsp_run_len,
   output logic                        rsp_no_valid_seen,
   output logic                        rsp_last_result,
   input  logic                        csr_wr_en,
   input  logic [COUNT_WIDTH-1:0]      csr_wr_data
);

   logic [COUNT_WIDTH-1:0]   limit_ff;
   item_type                 item_ff;
   logic                     item_valid_ff, item_valid_in;
   logic                     step_fire;
   logic                     accept;
   logic [RUN_CNT_WIDTH-1:0] emit_count;
   logic [RUN_CNT_WIDTH-1:0] push_count;
   run_type                  run0;
   run_type                  run1;
   run_type                  head;
   logic                     queue_room;

   assign step_fire = item_valid_ff && queue_room;
   assign req_ready = !item_valid_ff || step_fire;
   assign accept = req_valid && req_ready;
   assign item_valid_in = accept || (item_valid_ff && !step_fire);
   assign push_count = step_fire ? emit_count : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= '{value: req_value[VALUE_WIDTH-1:0], is_valid: req_is_valid,
                      end_of_stream: req_end_of_stream};
      end
   end

   rlen_step u_step (
      .clock      (clock),
      .reset      (reset),
      .fire       (step_fire),
      .item       (item_ff),
      .limit      (limit_ff),
      .emit_count (emit_count),
      .run0       (run0),
      .run1       (run1)
   );

   rlen_run_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_run0  (run0),
      .push_run1  (run1),
      .pop        (rsp_ready),
      .head       (head),
      .not_empty  (rsp_valid),
      .has_room   (queue_room)
   );

   assign rsp_run_value = PORT_VALUE_WIDTH'(head.run_value);
   assign rsp_run_len = head.run_len;
   assign rsp_no_valid_seen = head.no_valid_seen;
   assign rsp_last_result = head.last_result;

   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !step_fire |=> item_valid_ff && $stable(item_ff))
      else $error("Held row changed before it was processed.");

   assert property (@(posedge clock) disable iff (reset)
      step_fire |=> rsp_valid || $past(emit_count) == '0)
      else $error("Processed row produced runs but no word is offered.");

   assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> req_ready)
      else $error("Input refused while the input register is empty.");

endmodule
